// ===== src/lru_set_assoc_cache_sim_defines.svh =====
// ----------------------------------------------------------------------------
// lru_set_assoc_cache_sim_defines.svh
// Assertion macros shared by the cache simulator RTL.
// ----------------------------------------------------------------------------
`ifndef LRU_SET_ASSOC_CACHE_SIM_DEFINES_SVH
`define LRU_SET_ASSOC_CACHE_SIM_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define LSCS_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define LSCS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== src/lscs_pkg.sv =====
// ----------------------------------------------------------------------------
// lscs_pkg
// Fixed widths, codes and shared types of the cache simulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lscs_pkg;

    // Fixed field widths.
    localparam int ADDR_W     = 64;
    localparam int TAG_W      = 64;
    localparam int REQ_W      = 2;
    localparam int OC_W       = 2;
    localparam int SET_OUT_W  = 6;
    localparam int TOT_OUT_W  = 32;
    localparam int SETB_W     = 3;
    localparam int BLKB_W     = 6;
    localparam int WAYSR_W    = 3;
    localparam int SHIFT_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int OUT_DATA_W = OC_W + SET_OUT_W + 3 * TOT_OUT_W;

    // Request types.
    localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_STORE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MODIFY = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE   = 2'd3;

    // Lookup outcomes.
    localparam logic [OC_W-1:0] OC_HIT   = 2'd0;
    localparam logic [OC_W-1:0] OC_MISS  = 2'd1;
    localparam logic [OC_W-1:0] OC_EVICT = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

    // Status of one lookup, passed from the lookup logic to the top level.
    typedef struct packed {
        logic [OC_W-1:0] outcome;
        logic            hit;
        logic            miss;
        logic            evict;
    } t_lk_stat;

endpackage

// ===== src/lscs_ram.sv =====
// ----------------------------------------------------------------------------
// lscs_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lscs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/lscs_lookup.sv =====
// ----------------------------------------------------------------------------
// lscs_lookup
// Tag match, fill or LRU victim choice, and recency update of one set row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lscs_lookup #(
    parameter int MAX_WAYS = 4,
    parameter int WAY_W    = 2,
    parameter int CNT_W    = 3,
    parameter int ROW_W    = 268
) (
    input  logic [ROW_W-1:0]            i_row,
    input  logic                        i_row_init,
    input  logic [lscs_pkg::TAG_W-1:0]  i_tag,
    input  logic [CNT_W-1:0]            i_ways,
    output logic [ROW_W-1:0]            o_row,
    output lscs_pkg::t_lk_stat          o_stat
);

    import lscs_pkg::*;

    // Row layout: tags from bit zero, then valid bits, then the recency list.
    localparam int VAL_LO = MAX_WAYS * TAG_W;
    localparam int REC_LO = VAL_LO + MAX_WAYS;

    logic [TAG_W-1:0]    tags     [MAX_WAYS];
    logic [MAX_WAYS-1:0] valid;
    logic [WAY_W-1:0]    rec      [MAX_WAYS];
    logic [WAY_W-1:0]    new_rec  [MAX_WAYS];
    logic                hit_found;
    logic                inv_found;
    logic [WAY_W-1:0]    hit_way;
    logic [WAY_W-1:0]    inv_way;
    logic [WAY_W-1:0]    vic_way;
    logic [WAY_W-1:0]    sel_way;
    logic [WAY_W-1:0]    pos;

    // Unpack the row; a row never written reads as the reset contents.
    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (i_row_init) begin
                tags[w]  = '0;
                valid[w] = 1'b0;
                rec[w]   = WAY_W'(w);
            end else begin
                tags[w]  = i_row[w*TAG_W +: TAG_W];
                valid[w] = i_row[VAL_LO + w];
                rec[w]   = i_row[REC_LO + w*WAY_W +: WAY_W];
            end
        end
    end

    // Lowest matching way, lowest empty way, and least recent way in use.
    always_comb begin
        hit_found = 1'b0;
        hit_way   = '0;
        inv_found = 1'b0;
        inv_way   = '0;
        vic_way   = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if ((CNT_W'(w) < i_ways) && valid[w] && (tags[w] == i_tag)) begin
                hit_found = 1'b1;
                hit_way   = WAY_W'(w);
            end
            if ((CNT_W'(w) < i_ways) && !valid[w]) begin
                inv_found = 1'b1;
                inv_way   = WAY_W'(w);
            end
        end
        // The entry nearest the least recent end wins.
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (CNT_W'(rec[i]) < i_ways) begin
                vic_way = rec[i];
            end
        end
    end

    // Pick the way to touch and report the outcome.
    always_comb begin
        o_stat = '0;
        if (hit_found) begin
            sel_way        = hit_way;
            o_stat.outcome = OC_HIT;
            o_stat.hit     = 1'b1;
        end else if (inv_found) begin
            sel_way        = inv_way;
            o_stat.outcome = OC_MISS;
            o_stat.miss    = 1'b1;
        end else begin
            sel_way        = vic_way;
            o_stat.outcome = OC_EVICT;
            o_stat.miss    = 1'b1;
            o_stat.evict   = 1'b1;
        end
    end

    // Move the chosen way to the most recent place of the list.
    always_comb begin
        pos = WAY_W'(MAX_WAYS - 1);
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (rec[i] == sel_way) begin
                pos = WAY_W'(i);
            end
        end
        new_rec[0] = sel_way;
        for (int i = 1; i < MAX_WAYS; i++) begin
            new_rec[i] = (WAY_W'(i) <= pos) ? rec[i-1] : rec[i];
        end
    end

    // Repack the updated row; a miss writes the tag and sets the valid bit.
    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (!hit_found && (WAY_W'(w) == sel_way)) begin
                o_row[w*TAG_W +: TAG_W] = i_tag;
                o_row[VAL_LO + w]       = 1'b1;
            end else begin
                o_row[w*TAG_W +: TAG_W] = tags[w];
                o_row[VAL_LO + w]       = valid[w];
            end
            o_row[REC_LO + w*WAY_W +: WAY_W] = new_rec[w];
        end
    end

endmodule

// ===== src/lru_set_assoc_cache_sim.sv =====
// ----------------------------------------------------------------------------
// lru_set_assoc_cache_sim
// Set-associative cache simulator with true LRU replacement and hit totals.
// ----------------------------------------------------------------------------
// A load or store word first reads its set row from the row RAM, then looks
// up the tag, updates the row, writes it back and registers the result. A
// modify does a second lookup, which works on the row kept from the first.
// A word of request type three is taken and dropped without a result. Each
// set has a row-valid flip-flop that reset clears, so a set never written
// reads as empty with the reset recency order; no clearing pass runs after
// reset. Output back pressure holds the lookup until the result register is
// free. The user must see that configuration is written only while the block
// is idle; the block itself does not enforce this.
`timescale 1ns / 1ps

module lru_set_assoc_cache_sim #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 4,
    parameter int COUNT_WIDTH  = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write channel.
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [lscs_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lscs_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // Request stream.
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [lscs_pkg::ADDR_W-1:0]           i_s_axis_tdata,  // [63:0] address
    input  logic [lscs_pkg::REQ_W-1:0]            i_s_axis_tuser,  // [1:0] req_type
    // Result stream.
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // [1:0] outcome, [7:2] set_index, [39:8] total_hits,
    // [71:40] total_misses, [103:72] total_evictions
    output logic [lscs_pkg::OUT_DATA_W-1:0]       o_m_axis_tdata,
    output logic                                  o_m_axis_tlast   // is_last
);

    import lscs_pkg::*;

    `include "lru_set_assoc_cache_sim_defines.svh"

    localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int NUM_ROWS = 1 << SET_W;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CNT_W    = $clog2(MAX_WAYS + 1);
    localparam int ROW_W    = MAX_WAYS * (TAG_W + 1 + WAY_W);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LOOK1 = 2'd1;
    localparam logic [1:0] S_LOOK2 = 2'd2;

    localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

    logic [1:0]             r_state, n_state;
    logic [REQ_W-1:0]       r_req;
    logic [SET_W-1:0]       r_set;
    logic [TAG_W-1:0]       r_tag;
    logic [ROW_W-1:0]       r_row;
    logic [NUM_ROWS-1:0]    r_rowvalid;
    logic [SETB_W-1:0]      r_set_bits;
    logic [BLKB_W-1:0]      r_block_bits;
    logic [WAYSR_W-1:0]     r_ways;
    logic [COUNT_WIDTH-1:0] r_hits, r_misses, r_evicts;
    logic                   r_out_valid;
    logic [OC_W-1:0]        r_out_outcome;
    logic [SET_OUT_W-1:0]   r_out_set;
    logic                   r_out_last;

    logic [SHIFT_W-1:0]     sb_eff;
    logic [SHIFT_W-1:0]     shift;
    logic [CNT_W-1:0]       ways_eff;
    logic [ADDR_W-1:0]      set_full;
    logic [SET_W-1:0]       in_set;
    logic [TAG_W-1:0]       in_tag;
    logic                   s_fire;
    logic                   start;
    logic                   out_free;
    logic                   look_fire;
    logic                   is_last;
    logic [ROW_W-1:0]       ram_rdata;
    logic [ROW_W-1:0]       cur_row;
    logic                   cur_init;
    logic [ROW_W-1:0]       new_row;
    t_lk_stat               stat;

    // Handshakes.
    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;
    assign start           = s_fire && (i_s_axis_tuser != REQ_NONE);
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign look_fire       = (r_state != S_IDLE) && out_free;
    assign is_last         = !((r_state == S_LOOK1) && (r_req == REQ_MODIFY));

    // Effective geometry from the configuration registers.
    always_comb begin
        if (32'(r_set_bits) > MAX_SET_BITS) begin
            sb_eff = SHIFT_W'(MAX_SET_BITS);
        end else begin
            sb_eff = SHIFT_W'(r_set_bits);
        end
        if (r_ways == '0) begin
            ways_eff = CNT_W'(1);
        end else if (32'(r_ways) > MAX_WAYS) begin
            ways_eff = CNT_W'(MAX_WAYS);
        end else begin
            ways_eff = CNT_W'(r_ways);
        end
    end

    // Split the incoming address into set index and tag.
    assign shift    = sb_eff + SHIFT_W'(r_block_bits);
    assign set_full = i_s_axis_tdata >> r_block_bits;
    assign in_set   = set_full[SET_W-1:0] & ~({SET_W{1'b1}} << sb_eff);
    assign in_tag   = (32'(shift) >= ADDR_W) ? '0 : (i_s_axis_tdata >> shift);

    // Row RAM: one row holds the tags, valid bits and recency list of a set.
    lscs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_ROWS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (look_fire),
        .i_waddr (r_set),
        .i_wdata (new_row),
        .i_re    (start),
        .i_raddr (in_set),
        .o_rdata (ram_rdata)
    );

    // The second lookup of a modify works on the row left by the first.
    assign cur_row  = (r_state == S_LOOK2) ? r_row : ram_rdata;
    assign cur_init = (r_state == S_LOOK1) && !r_rowvalid[r_set];

    lscs_lookup #(
        .MAX_WAYS (MAX_WAYS),
        .WAY_W    (WAY_W),
        .CNT_W    (CNT_W),
        .ROW_W    (ROW_W)
    ) u_lookup (
        .i_row      (cur_row),
        .i_row_init (cur_init),
        .i_tag      (r_tag),
        .i_ways     (ways_eff),
        .o_row      (new_row),
        .o_stat     (stat)
    );

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_LOOK1;
                end
            end
            S_LOOK1: begin
                if (look_fire) begin
                    n_state = (r_req == REQ_MODIFY) ? S_LOOK2 : S_IDLE;
                end
            end
            S_LOOK2: begin
                if (look_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state, configuration and totals.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rowvalid   <= '0;
            r_set_bits   <= '0;
            r_block_bits <= '0;
            r_ways       <= WAYSR_W'(1);
            r_hits       <= '0;
            r_misses     <= '0;
            r_evicts     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SET_BITS:   r_set_bits   <= i_cfg_data[SETB_W-1:0];
                    CFG_BLOCK_BITS: r_block_bits <= i_cfg_data[BLKB_W-1:0];
                    CFG_WAYS:       r_ways       <= i_cfg_data[WAYSR_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (look_fire) begin
                r_rowvalid[r_set] <= 1'b1;
                if (stat.hit && (r_hits != CMAX)) begin
                    r_hits <= r_hits + 1'b1;
                end
                if (stat.miss && (r_misses != CMAX)) begin
                    r_misses <= r_misses + 1'b1;
                end
                if (stat.evict && (r_evicts != CMAX)) begin
                    r_evicts <= r_evicts + 1'b1;
                end
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request and result payload.
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_req <= i_s_axis_tuser;
            r_set <= in_set;
            r_tag <= in_tag;
        end
        if (look_fire) begin
            r_row         <= new_row;
            r_out_outcome <= stat.outcome;
            r_out_set     <= SET_OUT_W'(r_set);
            r_out_last    <= is_last;
        end
    end

    // Totals change only with a lookup, which also loads the result word.
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {TOT_OUT_W'(r_evicts), TOT_OUT_W'(r_misses),
                              TOT_OUT_W'(r_hits), r_out_set, r_out_outcome};

    // Checks.
    `LSCS_ASSERT_NEXT(a_look_gives_word, i_clk, i_rst_n, look_fire, o_m_axis_tvalid, "lookup without result word")
    `LSCS_ASSERT_NOW(a_look2_modify, i_clk, i_rst_n, r_state == S_LOOK2, r_req == REQ_MODIFY, "second lookup for a request that is not a modify")
    `LSCS_ASSERT_NEXT(a_single_done, i_clk, i_rst_n, look_fire && (r_state == S_LOOK1) && (r_req != REQ_MODIFY), r_state == S_IDLE, "single lookup did not return to idle")

endmodule

// ===== test/lru_set_assoc_cache_sim_tb.sv =====
// ----------------------------------------------------------------------------
// lru_set_assoc_cache_sim_tb
// Self-checking bench for the set-associative LRU cache simulator. A queue of
// requests feeds a clocked driver. A clocked monitor keeps its own cache
// image with tags, valid bits, recency order and totals. It predicts the
// lookups of every accepted request word and compares each result word
// field by field. A directed sequence comes first. Random phases follow
// under several cache geometries and back-pressure mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_set_assoc_cache_sim_tb;

    import lscs_pkg::*;

    localparam int NUM_SETS       = 64;
    localparam int NUM_WAYS       = 4;
    localparam int MODEL_MAX_SETB = 6;
    localparam int DRAIN_CYCLES   = 10;
    localparam int PHASE_ITEMS    = 172;

    typedef struct packed {
        logic [REQ_W-1:0]  kind;
        logic [ADDR_W-1:0] address;
    } t_cache_req;

    typedef struct packed {
        logic [OC_W-1:0]      outcome;
        logic [SET_OUT_W-1:0] set_index;
        logic                 last;
        logic [TOT_OUT_W-1:0] hits;
        logic [TOT_OUT_W-1:0] misses;
        logic [TOT_OUT_W-1:0] evictions;
    } t_lookup_res;

    // Clock, reset and block inputs, all known from time zero.
    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic [ADDR_W-1:0]     i_s_axis_tdata  = '0;  // [63:0] address
    logic [REQ_W-1:0]      i_s_axis_tuser  = '0;  // [1:0] req_type
    logic                  i_m_axis_tready = 1'b0;
    logic                  o_cfg_ready;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tlast;

    // Traffic control.
    t_cache_req     pending_requests[$];
    t_lookup_res    expected_lookups[$];
    logic           request_taken   = 1'b0;
    int unsigned    send_idle_pct   = 0;
    int unsigned    recv_idle_pct   = 0;
    int unsigned    mismatch_count  = 0;

    // Cache image of the bench.
    logic [TAG_W-1:0]     line_tag   [NUM_SETS][NUM_WAYS];
    logic                 line_valid [NUM_SETS][NUM_WAYS];
    logic [1:0]           lru_order  [NUM_SETS][NUM_WAYS];
    logic [TOT_OUT_W-1:0] hit_tally;
    logic [TOT_OUT_W-1:0] miss_tally;
    logic [TOT_OUT_W-1:0] evict_count;
    logic [SETB_W-1:0]    model_set_bits;
    logic [BLKB_W-1:0]    model_block_bits;
    logic [WAYSR_W-1:0]   model_ways;

    lru_set_assoc_cache_sim u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    // Set bits beyond the supported maximum behave as the maximum.
    function automatic int unsigned used_set_bits();
        return (model_set_bits > MODEL_MAX_SETB) ? MODEL_MAX_SETB : model_set_bits;
    endfunction

    // Zero ways behaves as one way, too many ways as all ways.
    function automatic int unsigned used_ways();
        if (model_ways == 0)
            return 1;
        return (model_ways > NUM_WAYS) ? NUM_WAYS : model_ways;
    endfunction

    // Move a way to the most recent slot of its set.
    function automatic void make_recent(int unsigned set_no, logic [1:0] way);
        int unsigned pos;
        pos = NUM_WAYS - 1;
        for (int i = 0; i < NUM_WAYS; i++) begin
            if (lru_order[set_no][i] == way) begin
                pos = i;
                break;
            end
        end
        while (pos > 0) begin
            lru_order[set_no][pos] = lru_order[set_no][pos-1];
            pos--;
        end
        lru_order[set_no][0] = way;
    endfunction

    // One tag lookup with fill or eviction; returns the outcome code.
    function automatic logic [OC_W-1:0] lookup_tag(int unsigned set_no, logic [TAG_W-1:0] tag);
        int unsigned n;
        logic [1:0]  victim;
        n = used_ways();
        for (int w = 0; w < n; w++) begin
            if (line_valid[set_no][w] && line_tag[set_no][w] == tag) begin
                make_recent(set_no, 2'(w));
                if (hit_tally != '1) hit_tally++;
                return OC_HIT;
            end
        end
        if (miss_tally != '1) miss_tally++;
        for (int w = 0; w < n; w++) begin
            if (!line_valid[set_no][w]) begin
                line_valid[set_no][w] = 1'b1;
                line_tag[set_no][w]   = tag;
                make_recent(set_no, 2'(w));
                return OC_MISS;
            end
        end
        // Set full: the least recent way still in use is the victim.
        victim = 2'd0;
        for (int i = NUM_WAYS - 1; i >= 0; i--) begin
            if (lru_order[set_no][i] < n) begin
                victim = lru_order[set_no][i];
                break;
            end
        end
        line_tag[set_no][victim]   = tag;
        line_valid[set_no][victim] = 1'b1;
        make_recent(set_no, victim);
        if (evict_count != '1) evict_count++;
        return OC_EVICT;
    endfunction

    // Expected result words of one accepted request word.
    function automatic void predict_request(t_cache_req req);
        int unsigned    sb;
        int unsigned    shift;
        int unsigned    set_no;
        int unsigned    lookups;
        logic [TAG_W-1:0] tag;
        t_lookup_res    res;
        if (req.kind == REQ_NONE)
            return;
        sb     = used_set_bits();
        shift  = sb + model_block_bits;
        tag    = (shift >= 64) ? '0 : (req.address >> shift);
        set_no = 32'((req.address >> model_block_bits) & ((64'd1 << sb) - 64'd1));
        lookups = (req.kind == REQ_MODIFY) ? 2 : 1;
        for (int k = 0; k < lookups; k++) begin
            res.outcome   = lookup_tag(set_no, tag);
            res.set_index = SET_OUT_W'(set_no);
            res.last      = (k == lookups - 1);
            res.hits      = hit_tally;
            res.misses    = miss_tally;
            res.evictions = evict_count;
            expected_lookups.push_back(res);
        end
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    // Addresses mostly reuse a few tags in a few sets so that hits and
    // evictions are common; one in ten is fully random.
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [ADDR_W-1:0] addr;
        logic [63:0]       tag;
        logic [63:0]       set_val;
        int unsigned       sb;
        int unsigned       shift;
        addr = {$urandom, $urandom};
        if ($urandom_range(9) == 0)
            return addr;
        sb      = used_set_bits();
        shift   = sb + model_block_bits;
        tag     = 64'($urandom_range(0, 5));
        set_val = ($urandom_range(1) == 0) ? 64'($urandom_range(0, 3)) : {$urandom, $urandom};
        set_val = set_val & ((64'd1 << sb) - 64'd1);
        addr    = addr & ((64'd1 << model_block_bits) - 64'd1);
        addr    = addr | (set_val << model_block_bits);
        if (shift < 64)
            addr = addr | (tag << shift);
        return addr;
    endfunction

    function automatic void queue_request(logic [REQ_W-1:0] kind, logic [ADDR_W-1:0] addr);
        t_cache_req req;
        req.kind    = kind;
        req.address = addr;
        pending_requests.push_back(req);
    endfunction

    // Wait until every word is sent and every result is back, then let the
    // pipeline settle in case a dropped word is still inside.
    task automatic wait_drained();
        while (pending_requests.size() != 0 || i_s_axis_tvalid || expected_lookups.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One configuration write; the bench image follows on acceptance.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SET_BITS: begin
                model_set_bits = val[SETB_W-1:0];
            end
            CFG_BLOCK_BITS: begin
                model_block_bits = val[BLKB_W-1:0];
            end
            CFG_WAYS: begin
                model_ways = val[WAYSR_W-1:0];
            end
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(int unsigned sb, int unsigned bb, int unsigned ways);
        wait_drained();
        write_reg(CFG_SET_BITS, CFG_DATA_W'(sb));
        write_reg(CFG_BLOCK_BITS, CFG_DATA_W'(bb));
        write_reg(CFG_WAYS, CFG_DATA_W'(ways));
    endtask

    // Random phase: mostly loads, stores and modifies, a few dropped words.
    task automatic run_random_phase(int unsigned sb, int unsigned bb, int unsigned ways);
        int unsigned counted;
        int unsigned roll;
        set_geometry(sb, bb, ways);
        counted = 0;
        while (counted < PHASE_ITEMS) begin
            roll = $urandom_range(99);
            if (roll < 5) begin
                queue_request(REQ_NONE, {$urandom, $urandom});
            end else begin
                queue_request(REQ_W'($urandom_range(REQ_LOAD, REQ_MODIFY)), pick_address());
                counted++;
            end
        end
    endtask

    // Request driver: a word stays on the bus until it is taken.
    always @(negedge i_clk) begin : request_driver
        t_cache_req next_req;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (!i_s_axis_tvalid || request_taken) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_req = pending_requests.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= next_req.address;
                    i_s_axis_tuser  <= next_req.kind;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: check result words, then predict for the accepted request word.
    always @(posedge i_clk) begin : cache_monitor
        t_lookup_res want;
        t_cache_req  seen;
        if (!i_rst_n) begin
            request_taken <= 1'b0;
        end else begin
            request_taken <= i_s_axis_tvalid && o_s_axis_tready;
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_lookups.size() == 0) begin
                    mismatch_count++;
                    $display("%0t ns: unexpected result word, expected none, actual %0h last %0b",
                             $time, o_m_axis_tdata, o_m_axis_tlast);
                end else begin
                    want = expected_lookups.pop_front();
                    check_field("outcome", want.outcome, o_m_axis_tdata[1:0]);
                    check_field("set_index", want.set_index, o_m_axis_tdata[7:2]);
                    check_field("total_hits", want.hits, o_m_axis_tdata[39:8]);
                    check_field("total_misses", want.misses, o_m_axis_tdata[71:40]);
                    check_field("total_evictions", want.evictions, o_m_axis_tdata[103:72]);
                    check_field("is_last", want.last, o_m_axis_tlast);
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                seen.kind    = i_s_axis_tuser;
                seen.address = i_s_axis_tdata;
                predict_request(seen);
            end
        end
    end

    // Stimulus sequence.
    initial begin
        for (int s = 0; s < NUM_SETS; s++) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                line_tag[s][w]   = '0;
                line_valid[s][w] = 1'b0;
                lru_order[s][w]  = 2'(w);
            end
        end
        hit_tally        = '0;
        miss_tally       = '0;
        evict_count      = '0;
        model_set_bits   = '0;
        model_block_bits = '0;
        model_ways       = 3'd1;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: four sets, 16-byte lines, two ways.
        send_idle_pct = 31;
        recv_idle_pct = 80;
        set_geometry(2, 4, 2);
        queue_request(REQ_LOAD, 64'h0);
        queue_request(REQ_LOAD, 64'h8);
        queue_request(REQ_STORE, 64'h40);
        queue_request(REQ_MODIFY, 64'h80);
        queue_request(REQ_LOAD, 64'h0);
        queue_request(REQ_NONE, 64'h40);
        queue_request(REQ_LOAD, 64'h40);
        queue_request(REQ_LOAD, '1);
        queue_request(REQ_MODIFY, '1);
        queue_request(REQ_STORE, 64'h10);
        queue_request(REQ_MODIFY, 64'h20);
        queue_request(REQ_NONE, '1);
        queue_request(REQ_STORE, 64'h8000_0000_0000_0000);
        queue_request(REQ_LOAD, 64'h30);
        queue_request(REQ_STORE, 64'hF0);

        // Random phases under slow receiver: lowest settings, small, widest shift.
        run_random_phase(0, 0, 1);
        run_random_phase(1, 3, 4);
        run_random_phase(6, 57, 4);

        // Slow sender: oversized set bits, tag shifted out, zero ways.
        wait_drained();
        send_idle_pct = 80;
        recv_idle_pct = 31;
        run_random_phase(7, 6, 3);
        run_random_phase(3, 63, 2);
        run_random_phase(6, 0, 0);

        // Full rate: oversized associativity, then shrinking it.
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(2, 5, 7);
        run_random_phase(4, 58, 5);
        run_random_phase(5, 2, 2);

        wait_drained();
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Hang guard.
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
